[rtl/crpi_pkg.sv]
// Shared widths, types, coefficient forms and saturation for the route interpolator.
`timescale 1ns / 1ps

package crpi_pkg;

   // Coordinate and t-grid widths
   localparam int COORD_WIDTH   = 24;
   localparam int T_FRAC_BITS   = 16;
   localparam int COEF_WIDTH    = COORD_WIDTH + 4;
   localparam int ACC_WIDTH     = COORD_WIDTH + 5;
   localparam int TQ_WIDTH      = T_FRAC_BITS + 1;
   localparam int F_WIDTH       = 5;
   localparam int REM_WIDTH     = F_WIDTH + 1;
   localparam int DIV_CNT_WIDTH = $clog2(TQ_WIDTH);

   // Samples per segment limits
   localparam logic [F_WIDTH-1:0] F_MIN   = F_WIDTH'(1);
   localparam logic [F_WIDTH-1:0] F_MAX   = F_WIDTH'(30);
   localparam logic [F_WIDTH-1:0] F_RESET = F_WIDTH'(16);

   // Segment form codes
   localparam int FORM_WIDTH = 2;
   localparam logic [FORM_WIDTH-1:0] FORM_START = 2'd0;
   localparam logic [FORM_WIDTH-1:0] FORM_CUBIC = 2'd1;
   localparam logic [FORM_WIDTH-1:0] FORM_END   = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic signed [ACC_WIDTH-1:0]   acc_type;
   typedef logic        [TQ_WIDTH-1:0]    tq_type;

   typedef struct packed {
      coef_type a;
      coef_type b;
      coef_type c;
      coef_type d;
   } poly_type;

   // Saturation bounds on the halved accumulator
   localparam logic signed [ACC_WIDTH:0] SAT_HI =
      (ACC_WIDTH+1)'((longint'(1) <<< (COORD_WIDTH-1)) - 1);
   localparam logic signed [ACC_WIDTH:0] SAT_LO =
      (ACC_WIDTH+1)'(-(longint'(1) <<< (COORD_WIDTH-1)));

   // Build doubled polynomial coefficients from the window and the new point
   function automatic poly_type form_poly(input logic [FORM_WIDTH-1:0] form,
                                          input coord_type w0, input coord_type w1,
                                          input coord_type w2, input coord_type pt);
      coef_type e0;
      coef_type e1;
      coef_type e2;
      coef_type e3;
      poly_type p;
      e0 = coef_type'(w0);
      e1 = coef_type'(w1);
      e2 = coef_type'(w2);
      e3 = coef_type'(pt);
      unique case (form)
         FORM_START: begin
            p.a = '0;
            p.b = e1 - (e2 <<< 1) + e3;
            p.c = (e2 <<< 2) - ((e1 <<< 1) + e1) - e3;
            p.d = e1 <<< 1;
         end
         FORM_CUBIC: begin
            p.a = ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
            p.b = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
            p.c = e2 - e0;
            p.d = e1 <<< 1;
         end
         default: begin
            p.a = '0;
            p.b = e1 - (e2 <<< 1) + e3;
            p.c = e3 - e1;
            p.d = e2 <<< 1;
         end
      endcase
      return p;
   endfunction

   // Halve with rounding up and clip to the coordinate range
   function automatic coord_type sample_sat(input acc_type acc);
      logic signed [ACC_WIDTH:0] wide;
      wide = {acc[ACC_WIDTH-1], acc};
      wide = wide + (ACC_WIDTH+1)'(1);
      wide = wide >>> 1;
      if (wide > SAT_HI) begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (wide < SAT_LO) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end
      return wide[COORD_WIDTH-1:0];
   endfunction

endpackage

[rtl/catmull_rom_path_interpolator_top.sv]
// Catmull-Rom route interpolator: waypoint window, t-step divider, Horner sequencer.
`timescale 1ns / 1ps

// Waypoints enter one per transaction and each one is worked on alone; req_stall stays high
// until its last result has gone out. The first two waypoints of a route are shifted into the
// window and give nothing. Later waypoints first run a shift-subtract divider for the t step,
// then a form state per segment and, per sample, three Horner steps for x and three for y on
// the single shared multiplier, then an output state that holds while rsp_stall is high.
// A route ending before its third waypoint gives one result with too_short set.
module catmull_rom_path_interpolator_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [crpi_pkg::COORD_WIDTH-1:0] req_way_x,
   input  logic signed [crpi_pkg::COORD_WIDTH-1:0] req_way_y,
   input  logic                                  req_route_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [crpi_pkg::COORD_WIDTH-1:0] rsp_sample_x,
   output logic signed [crpi_pkg::COORD_WIDTH-1:0] rsp_sample_y,
   output logic                                  rsp_run_last,
   output logic                                  rsp_too_short,
   input  logic                                  csr_wr_en,
   input  logic [crpi_pkg::F_WIDTH-1:0]          csr_wr_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_FORM = 3'd2;
   localparam logic [2:0] ST_MAC  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam int FW = crpi_pkg::F_WIDTH;
   localparam int RW = crpi_pkg::REM_WIDTH;
   localparam int QW = crpi_pkg::TQ_WIDTH;
   localparam int CW = crpi_pkg::DIV_CNT_WIDTH;

   logic [2:0] state_ff, state_in;
   logic [FW-1:0] f_cfg_ff;
   crpi_pkg::coord_type win_x_ff [3];
   crpi_pkg::coord_type win_x_in [3];
   crpi_pkg::coord_type win_y_ff [3];
   crpi_pkg::coord_type win_y_in [3];
   logic [1:0] points_ff, points_in;
   crpi_pkg::coord_type pt_x_ff, pt_x_in, pt_y_ff, pt_y_in;
   logic end_ff, end_in;
   logic [1:0] seen_ff, seen_in;
   logic [FW-1:0] f_ff, f_in;
   logic [QW-1:0] k_ff, k_in, q_ff, q_in;
   logic [RW-1:0] m_ff, m_in, r_ff, r_in, div_rem_ff, div_rem_in;
   logic [CW-1:0] div_cnt_ff, div_cnt_in;
   logic run_ff, run_in;
   logic [crpi_pkg::FORM_WIDTH-1:0] form_ff, form_in;
   logic [FW-1:0] i_ff, i_in;
   crpi_pkg::poly_type poly_x_ff, poly_x_in, poly_y_ff, poly_y_in;
   crpi_pkg::acc_type acc_ff, acc_in, acc_next;
   logic [2:0] step_ff, step_in;
   crpi_pkg::coord_type sx_ff, sx_in;
   logic rsp_valid_ff, rsp_valid_in;
   crpi_pkg::coord_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic rsp_last_ff, rsp_last_in, rsp_short_ff, rsp_short_in;

   crpi_pkg::coef_type addend;
   logic [FW-1:0] last_i;
   logic [FW-1:0] f_clamp;
   logic [RW-1:0] rem_shift;
   logic [RW-1:0] r_sum;
   logic req_accept;
   logic rsp_accept;

   // Shared Horner unit
   crpi_mac u_mac (
      .acc      (acc_ff),
      .tq       (q_ff),
      .addend   (addend),
      .acc_next (acc_next)
   );

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign last_i     = run_ff ? f_ff : f_ff - FW'(1);
   assign rem_shift  = {div_rem_ff[RW-2:0], (div_cnt_ff == '0)};
   assign r_sum      = r_ff + m_ff;

   // Clamp the programmed sample count
   always_comb begin
      if (f_cfg_ff < crpi_pkg::F_MIN) begin
         f_clamp = crpi_pkg::F_MIN;
      end else if (f_cfg_ff > crpi_pkg::F_MAX) begin
         f_clamp = crpi_pkg::F_MAX;
      end else begin
         f_clamp = f_cfg_ff;
      end
   end

   // Pick the coefficient for the current Horner step
   always_comb begin
      case (step_ff)
         3'd0:    addend = poly_x_ff.b;
         3'd1:    addend = poly_x_ff.c;
         3'd2:    addend = poly_x_ff.d;
         3'd3:    addend = poly_y_ff.b;
         3'd4:    addend = poly_y_ff.c;
         default: addend = poly_y_ff.d;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      win_x_in     = win_x_ff;
      win_y_in     = win_y_ff;
      points_in    = points_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      end_in       = end_ff;
      seen_in      = seen_ff;
      f_in         = f_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      div_rem_in   = div_rem_ff;
      div_cnt_in   = div_cnt_ff;
      run_in       = run_ff;
      form_in      = form_ff;
      i_in         = i_ff;
      poly_x_in    = poly_x_ff;
      poly_y_in    = poly_y_ff;
      acc_in       = acc_ff;
      step_in      = step_ff;
      sx_in        = sx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_short_in = rsp_short_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               pt_x_in    = req_way_x;
               pt_y_in    = req_way_y;
               end_in     = req_route_end;
               seen_in    = points_ff;
               f_in       = f_clamp;
               div_rem_in = '0;
               div_cnt_in = '0;
               k_in       = '0;
               if (points_ff < 2'd2) begin
                  if (req_route_end) begin
                     // Route too short: one error transaction, then clear the route
                     rsp_valid_in = 1'b1;
                     rsp_x_in     = '0;
                     rsp_y_in     = '0;
                     rsp_last_in  = 1'b1;
                     rsp_short_in = 1'b1;
                     state_in     = ST_OUT;
                  end else begin
                     // Early waypoint: shift it in, no result
                     win_x_in  = '{win_x_ff[1], win_x_ff[2], req_way_x};
                     win_y_in  = '{win_y_ff[1], win_y_ff[2], req_way_y};
                     points_in = points_ff + 2'd1;
                  end
               end else begin
                  state_in = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            // One quotient bit of 2^T / F per cycle
            if (rem_shift >= RW'(f_ff)) begin
               div_rem_in = rem_shift - RW'(f_ff);
               k_in       = {k_ff[QW-2:0], 1'b1};
            end else begin
               div_rem_in = rem_shift;
               k_in       = {k_ff[QW-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + CW'(1);
            if (div_cnt_ff == CW'(QW - 1)) begin
               m_in     = div_rem_in;
               run_in   = 1'b0;
               form_in  = (seen_ff == 2'd2) ? crpi_pkg::FORM_START : crpi_pkg::FORM_CUBIC;
               i_in     = '0;
               q_in     = '0;
               r_in     = RW'(f_ff >> 1);
               state_in = ST_FORM;
            end
         end

         ST_FORM: begin
            poly_x_in = crpi_pkg::form_poly(form_ff, win_x_ff[0], win_x_ff[1], win_x_ff[2],
                                            pt_x_ff);
            poly_y_in = crpi_pkg::form_poly(form_ff, win_y_ff[0], win_y_ff[1], win_y_ff[2],
                                            pt_y_ff);
            acc_in    = crpi_pkg::acc_type'(poly_x_in.a);
            step_in   = '0;
            state_in  = ST_MAC;
         end

         ST_MAC: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) begin
               sx_in  = crpi_pkg::sample_sat(acc_next);
               acc_in = crpi_pkg::acc_type'(poly_y_ff.a);
            end else if (step_ff == 3'd5) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = sx_ff;
               rsp_y_in     = crpi_pkg::sample_sat(acc_next);
               rsp_last_in  = (i_ff == last_i) && (run_ff || !end_ff);
               rsp_short_in = 1'b0;
               state_in     = ST_OUT;
            end else begin
               acc_in = acc_next;
            end
         end

         ST_OUT: begin
            if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  // Item done: retire the waypoint or close the route
                  if (end_ff) begin
                     win_x_in  = '{'0, '0, '0};
                     win_y_in  = '{'0, '0, '0};
                     points_in = 2'd0;
                  end else begin
                     win_x_in  = '{win_x_ff[1], win_x_ff[2], pt_x_ff};
                     win_y_in  = '{win_y_ff[1], win_y_ff[2], pt_y_ff};
                     points_in = (points_ff == 2'd3) ? 2'd3 : points_ff + 2'd1;
                  end
                  state_in = ST_IDLE;
               end else if (i_ff == last_i) begin
                  // Move on to the end segment
                  run_in   = 1'b1;
                  form_in  = crpi_pkg::FORM_END;
                  i_in     = '0;
                  q_in     = '0;
                  r_in     = RW'(f_ff >> 1);
                  state_in = ST_FORM;
               end else begin
                  // Advance t by F-th steps, carrying the remainder
                  i_in = i_ff + FW'(1);
                  if (r_sum >= RW'(f_ff)) begin
                     r_in = r_sum - RW'(f_ff);
                     q_in = q_ff + k_ff + QW'(1);
                  end else begin
                     r_in = r_sum;
                     q_in = q_ff + k_ff;
                  end
                  acc_in   = crpi_pkg::acc_type'(poly_x_ff.a);
                  step_in  = '0;
                  state_in = ST_MAC;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         f_cfg_ff     <= crpi_pkg::F_RESET;
         win_x_ff     <= '{'0, '0, '0};
         win_y_ff     <= '{'0, '0, '0};
         points_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_x_ff     <= win_x_in;
         win_y_ff     <= win_y_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            f_cfg_ff <= csr_wr_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pt_x_ff      <= pt_x_in;
      pt_y_ff      <= pt_y_in;
      end_ff       <= end_in;
      seen_ff      <= seen_in;
      f_ff         <= f_in;
      k_ff         <= k_in;
      m_ff         <= m_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      div_rem_ff   <= div_rem_in;
      div_cnt_ff   <= div_cnt_in;
      run_ff       <= run_in;
      form_ff      <= form_in;
      i_ff         <= i_in;
      poly_x_ff    <= poly_x_in;
      poly_y_ff    <= poly_y_in;
      acc_ff       <= acc_in;
      step_ff      <= step_in;
      sx_ff        <= sx_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_short_ff <= rsp_short_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample_x  = rsp_x_ff;
   assign rsp_sample_y  = rsp_y_ff;
   assign rsp_run_last  = rsp_last_ff;
   assign rsp_too_short = rsp_short_ff;

`ifndef SYNTHESIS
   // A pending result keeps the input side closed
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   // Error transaction is final and carries zero samples
   a_short_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_short) |->
         (rsp_run_last && rsp_sample_x == '0 && rsp_sample_y == '0))
      else $error("malformed too_short result");

   // Last result of an item reopens the input next cycle
   a_reopen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_run_last) |=> !req_stall)
      else $error("input not reopened after last result");
`endif

endmodule

[rtl/crpi_mac.sv]
// Shared Horner step: rounded multiply of the accumulator by t, plus a coefficient.
`timescale 1ns / 1ps

module crpi_mac (
   input  crpi_pkg::acc_type  acc,
   input  crpi_pkg::tq_type   tq,
   input  crpi_pkg::coef_type addend,
   output crpi_pkg::acc_type  acc_next
);

   localparam int PROD_WIDTH = crpi_pkg::ACC_WIDTH + crpi_pkg::TQ_WIDTH + 1;
   localparam logic signed [PROD_WIDTH-1:0] ROUND =
      PROD_WIDTH'(longint'(1) <<< (crpi_pkg::T_FRAC_BITS - 1));

   logic signed [PROD_WIDTH-1:0] prod;
   logic signed [PROD_WIDTH-1:0] shifted;

   // Multiply, round to nearest on the t grid, add the next coefficient
   always_comb begin
      prod     = PROD_WIDTH'(acc) * PROD_WIDTH'($signed({1'b0, tq}));
      shifted  = (prod + ROUND) >>> crpi_pkg::T_FRAC_BITS;
      acc_next = crpi_pkg::acc_type'(shifted[crpi_pkg::ACC_WIDTH-1:0])
               + crpi_pkg::acc_type'(addend);
   end

endmodule
